// ===== hdl/mbf_pkg.sv =====
// shared types and constants of the modbus tcp header framer
package mbf_pkg;

    // input selector codes (s_tuser)
    localparam logic [1:0] FUNC_TX_HDR  = 2'd0;
    localparam logic [1:0] FUNC_TX_BYTE = 2'd1;
    localparam logic [1:0] FUNC_RX_BYTE = 2'd2;

    // result kind codes (m_tuser)
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_RX_PAY = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // status codes
    localparam logic [2:0] ST_GOOD      = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_PROTOCOL  = 3'd3;
    localparam logic [2:0] ST_LENGTH    = 3'd4;
    localparam logic [2:0] ST_TRANSACT  = 3'd5;

    // header geometry
    localparam int HDR_BYTES       = 8;
    localparam int PREFIX_BYTES    = 6;
    localparam int UNIT_FUNC_BYTES = 2;

    // receive byte counter, saturating
    localparam int RX_COUNT_W = 11;

    // descriptor queue between front and back
    localparam int QDEPTH = 4;
    localparam int QIDX_W = 2;
    localparam int QCNT_W = 3;

    // how the back expands one descriptor
    typedef enum logic [1:0] {
        OP_SINGLE,
        OP_PAIR,
        OP_HEADER
    } mbf_op_t;

    typedef struct packed {
        mbf_op_t     op;
        logic [1:0]  kind;
        logic        last;
        logic [7:0]  data;
        logic [15:0] tid;
        logic [15:0] len;
        logic [7:0]  unit;
        logic [7:0]  fcode;
        logic [7:0]  count;
        logic [2:0]  status;
    } mbf_desc_t;

endpackage

// ===== hdl/mbf_front.sv =====
// front end: accepts items, tracks transaction and receive state, builds descriptors
module mbf_front #(
    parameter int FRAME_BYTES = 260
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          func,
    input  logic [7:0]          data_byte,
    input  logic [7:0]          unit_id,
    input  logic [7:0]          function_code,
    input  logic [15:0]         payload_length,
    input  logic                frame_end,
    input  logic                server_mode,
    input  logic [7:0]          max_read_payload,
    input  logic                q_full,
    output logic                push,
    output mbf_pkg::mbf_desc_t  push_desc
);
    import mbf_pkg::*;

    localparam int PAYLOAD_CAP = FRAME_BYTES - HDR_BYTES;
    localparam logic [15:0] TX_MAX = 16'(PAYLOAD_CAP);
    localparam logic [RX_COUNT_W-1:0] CAP_W = RX_COUNT_W'(PAYLOAD_CAP);
    localparam logic [RX_COUNT_W-1:0] FRAME_W = RX_COUNT_W'(FRAME_BYTES);
    localparam logic [RX_COUNT_W-1:0] HDR_W = RX_COUNT_W'(HDR_BYTES);
    localparam logic [RX_COUNT_W-1:0] PREFIX_W = RX_COUNT_W'(PREFIX_BYTES);
    localparam logic [RX_COUNT_W-1:0] CNT_MAX = {RX_COUNT_W{1'b1}};

    logic [15:0]           tid_reg, tid_next;
    logic                  adv_reg, adv_next;
    logic [RX_COUNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]           rtid_reg, rtid_next;
    logic                  pbad_reg, pbad_next;
    logic [15:0]           rlen_reg, rlen_next;
    logic [7:0]            runit_reg, runit_next;
    logic [7:0]            rfunc_reg, rfunc_next;

    logic                  accept;
    logic [7:0]            limit;
    logic [RX_COUNT_W-1:0] pos;
    logic [RX_COUNT_W-1:0] after_hdr;
    logic                  emit;
    logic [2:0]            st;
    logic [RX_COUNT_W-1:0] pay_cnt;
    logic [7:0]            cnt_out;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // effective payload limit: min(max_read_payload, frame capacity)
    assign limit = (RX_COUNT_W'(max_read_payload) > CAP_W) ? CAP_W[7:0] : max_read_payload;

    always_comb begin
        tid_next   = tid_reg;
        adv_next   = adv_reg;
        cnt_next   = cnt_reg;
        rtid_next  = rtid_reg;
        pbad_next  = pbad_reg;
        rlen_next  = rlen_reg;
        runit_next = runit_reg;
        rfunc_next = rfunc_reg;
        push       = 1'b0;
        push_desc  = '0;
        pos        = cnt_reg;
        after_hdr  = cnt_reg - HDR_W;
        emit       = 1'b0;
        st         = ST_GOOD;
        pay_cnt    = '0;
        cnt_out    = '0;

        if (accept) begin
            unique case (func)
                FUNC_TX_HDR: begin
                    if (!server_mode) begin
                        tid_next = tid_reg + {15'd0, adv_reg};
                        adv_next = 1'b1;
                    end
                    push = 1'b1;
                    if (payload_length > TX_MAX) begin
                        push_desc.op     = OP_SINGLE;
                        push_desc.kind   = KIND_STATUS;
                        push_desc.last   = 1'b1;
                        push_desc.status = ST_OVERFLOW;
                    end else begin
                        push_desc.op    = OP_HEADER;
                        push_desc.tid   = tid_next;
                        push_desc.len   = payload_length + 16'(UNIT_FUNC_BYTES);
                        push_desc.unit  = unit_id;
                        push_desc.fcode = function_code;
                    end
                end
                FUNC_TX_BYTE: begin
                    push           = 1'b1;
                    push_desc.op   = OP_SINGLE;
                    push_desc.kind = KIND_TX;
                    push_desc.last = 1'b1;
                    push_desc.data = data_byte;
                end
                FUNC_RX_BYTE: begin
                    // header capture by position
                    case (pos)
                        11'd0: rtid_next = {data_byte, rtid_reg[7:0]};
                        11'd1: rtid_next = {rtid_reg[15:8], data_byte};
                        11'd2, 11'd3: if (data_byte != 8'd0) pbad_next = 1'b1;
                        11'd4: rlen_next = {data_byte, rlen_reg[7:0]};
                        11'd5: rlen_next = {rlen_reg[15:8], data_byte};
                        11'd6: runit_next = data_byte;
                        11'd7: rfunc_next = data_byte;
                        default: emit = (after_hdr < RX_COUNT_W'(limit));
                    endcase
                    if (cnt_reg != CNT_MAX) cnt_next = cnt_reg + 1'b1;

                    if (frame_end) begin
                        // checks in priority order
                        if (cnt_next < HDR_W) begin
                            st = ST_SHORT;
                        end else if (pbad_next) begin
                            st = ST_PROTOCOL;
                        end else if (cnt_next > FRAME_W ||
                                     rlen_next != 16'(cnt_next - PREFIX_W)) begin
                            st = ST_LENGTH;
                        end else if (server_mode) begin
                            tid_next = rtid_next;
                        end else if (tid_reg != rtid_next) begin
                            st = ST_TRANSACT;
                        end
                        if (st == ST_GOOD) begin
                            pay_cnt = cnt_next - HDR_W;
                            cnt_out = (pay_cnt > RX_COUNT_W'(limit)) ? limit : pay_cnt[7:0];
                        end
                        push             = 1'b1;
                        push_desc.op     = emit ? OP_PAIR : OP_SINGLE;
                        push_desc.kind   = KIND_STATUS;
                        push_desc.last   = 1'b1;
                        push_desc.data   = emit ? data_byte : 8'd0;
                        push_desc.unit   = runit_next;
                        push_desc.fcode  = rfunc_next;
                        push_desc.count  = cnt_out;
                        push_desc.status = st;
                        // receive state back to idle
                        cnt_next   = '0;
                        rtid_next  = '0;
                        pbad_next  = 1'b0;
                        rlen_next  = '0;
                        runit_next = '0;
                        rfunc_next = '0;
                    end else if (emit) begin
                        push           = 1'b1;
                        push_desc.op   = OP_SINGLE;
                        push_desc.kind = KIND_RX_PAY;
                        push_desc.last = 1'b1;
                        push_desc.data = data_byte;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tid_reg   <= '0;
            adv_reg   <= 1'b0;
            cnt_reg   <= '0;
            rtid_reg  <= '0;
            pbad_reg  <= 1'b0;
            rlen_reg  <= '0;
            runit_reg <= '0;
            rfunc_reg <= '0;
        end else begin
            tid_reg   <= tid_next;
            adv_reg   <= adv_next;
            cnt_reg   <= cnt_next;
            rtid_reg  <= rtid_next;
            pbad_reg  <= pbad_next;
            rlen_reg  <= rlen_next;
            runit_reg <= runit_next;
            rfunc_reg <= rfunc_next;
        end
    end

endmodule

// ===== hdl/mbf_queue.sv =====
// small descriptor fifo between front and back
module mbf_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  mbf_pkg::mbf_desc_t  push_desc,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output mbf_pkg::mbf_desc_t  head_desc
);
    import mbf_pkg::*;

    mbf_desc_t          mem [QDEPTH];
    logic [QIDX_W-1:0]  wr_ptr_reg;
    logic [QIDX_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== hdl/mbf_back.sv =====
// back end: expands descriptors into result transactions through an output register
module mbf_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  mbf_pkg::mbf_desc_t  head_desc,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);
    import mbf_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_val;
        logic       last;
        logic [7:0] unit;
        logic [7:0] fcode;
        logic [7:0] count;
        logic [2:0] status;
    } res_t;

    logic       valid_reg;
    logic [2:0] step_reg;
    res_t       res_reg;
    res_t       res;
    logic       load;
    logic       item_done;

    always_comb begin
        res       = '0;
        item_done = 1'b1;
        unique case (head_desc.op)
            OP_SINGLE: begin
                res.kind     = head_desc.kind;
                res.byte_val = head_desc.data;
                res.last     = head_desc.last;
                res.unit     = head_desc.unit;
                res.fcode    = head_desc.fcode;
                res.count    = head_desc.count;
                res.status   = head_desc.status;
            end
            OP_PAIR: begin
                // payload byte first, then status
                if (step_reg == 3'd0) begin
                    res.kind     = KIND_RX_PAY;
                    res.byte_val = head_desc.data;
                    item_done    = 1'b0;
                end else begin
                    res.kind   = KIND_STATUS;
                    res.last   = 1'b1;
                    res.unit   = head_desc.unit;
                    res.fcode  = head_desc.fcode;
                    res.count  = head_desc.count;
                    res.status = head_desc.status;
                end
            end
            OP_HEADER: begin
                res.kind  = KIND_TX;
                item_done = (step_reg == 3'd7);
                res.last  = item_done;
                case (step_reg)
                    3'd0:    res.byte_val = head_desc.tid[15:8];
                    3'd1:    res.byte_val = head_desc.tid[7:0];
                    3'd4:    res.byte_val = head_desc.len[15:8];
                    3'd5:    res.byte_val = head_desc.len[7:0];
                    3'd6:    res.byte_val = head_desc.unit;
                    3'd7:    res.byte_val = head_desc.fcode;
                    default: res.byte_val = 8'd0;
                endcase
            end
            default: ;
        endcase
    end

    assign load = head_valid && (!valid_reg || m_tready);
    assign pop  = load && item_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                step_reg  <= item_done ? 3'd0 : step_reg + 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) res_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {5'd0, res_reg.status, res_reg.count, res_reg.fcode,
                       res_reg.unit, res_reg.byte_val};

endmodule

// ===== hdl/modbus_tcp_header_framer.sv =====
// top level of the modbus tcp header framer: config registers, front, queue and back
//
// builds and checks the eight-byte modbus tcp header (transaction id, protocol id,
// length, unit, function). one input transaction is taken per clock while the
// descriptor queue has room. transmit payload bytes and received frame bytes each
// produce at most one or two results and a header request eight header bytes;
// the back end drains them at one per cycle unless the output stalls, while the
// four-entry queue keeps the input side accepting. the output register lets the
// next result load in the cycle the current one is taken. received payload is
// sent before the frame is checked; the status result at frame end says whether
// to keep it (payload_count is zero on error). configuration must be written by the
// user over the apb port only while the block is idle; the block does not check it.
module modbus_tcp_header_framer #(
    parameter int FRAME_BYTES = 260
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte, unit_id, function_code, payload_length
    input  logic [1:0]  s_tuser,   // func
    input  logic        s_tlast,   // frame_end
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_byte, rx_unit_id, rx_function_code,
                                   // payload_count, status, zero pad
    output logic [1:0]  m_tuser,   // out_kind
    output logic        m_tlast,   // last
    // apb config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mbf_pkg::*;

    localparam logic REG_SERVER_MODE = 1'b0;
    localparam logic REG_MAX_READ    = 1'b1;

    logic       server_mode_reg;
    logic [7:0] max_read_reg;
    logic       cfg_write;

    logic       q_full;
    logic       push;
    mbf_desc_t  push_desc;
    logic       pop;
    logic       head_valid;
    mbf_desc_t  head_desc;

    // apb: zero wait states, register index from the word address
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            server_mode_reg <= 1'b0;
            max_read_reg    <= 8'd252;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_SERVER_MODE: server_mode_reg <= pwdata[0];
                REG_MAX_READ:    max_read_reg    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SERVER_MODE: prdata = {31'd0, server_mode_reg};
            REG_MAX_READ:    prdata = {24'd0, max_read_reg};
            default:         prdata = '0;
        endcase
    end

    // front: classify and update header / receive state
    mbf_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .func            (s_tuser),
        .data_byte       (s_tdata[7:0]),
        .unit_id         (s_tdata[15:8]),
        .function_code   (s_tdata[23:16]),
        .payload_length  (s_tdata[39:24]),
        .frame_end       (s_tlast),
        .server_mode     (server_mode_reg),
        .max_read_payload(max_read_reg),
        .q_full          (q_full),
        .push            (push),
        .push_desc       (push_desc)
    );

    // queue decouples the input side from the header drain
    mbf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_desc (head_desc)
    );

    // back: one result per cycle into the output register unless the output stalls
    mbf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_valid(head_valid),
        .head_desc (head_desc),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== bench/modbus_tcp_header_framer_tb.sv =====
// testbench for the modbus tcp header framer: predictor, stimulus tests and result checker
`timescale 1ns / 100ps

module modbus_tcp_header_framer_tb;
    import mbf_pkg::*;

    localparam int FRAME_BYTES = 260;
    // selector value the block ignores
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // apb register addresses
    localparam logic [2:0] REG_SERVER_MODE = 3'd0;
    localparam logic [2:0] REG_MAX_READ    = 3'd4;
    // receive byte counter ceiling
    localparam logic [10:0] RX_SEEN_MAX = 11'd2047;
    // cycles to let the back end finish before a register write or the end
    localparam int DRAIN_CYCLES = 40;
    // cycles without any transaction before the run is declared hung
    localparam int WATCHDOG_LIMIT = 4000;
    // random input transactions per idling phase
    localparam int PHASE_ITEMS = 65;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  data_byte;
        logic [7:0]  unit_id;
        logic [7:0]  function_code;
        logic [15:0] payload_length;
        logic        frame_end;
    } framer_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       last;
        logic [7:0] unit;
        logic [7:0] fcode;
        logic [7:0] count;
        logic [2:0] status;
    } framer_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // data_byte, unit_id, function_code, payload_length
    logic [1:0]  s_tuser;   // func
    logic        s_tlast;   // frame_end
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // out_byte, rx_unit_id, rx_function_code, payload_count,
                            // status, zero pad
    logic [1:0]  m_tuser;   // out_kind
    logic        m_tlast;   // last
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    modbus_tcp_header_framer #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor copy of the configuration registers
    logic        cfg_server_mode = 1'b0;
    logic [7:0]  cfg_max_read    = 8'd252;
    // predictor copy of the transmit and receive state
    logic [15:0] hdr_tid      = '0;
    logic        hdr_bump     = 1'b0;
    logic [10:0] rx_seen      = '0;
    logic [15:0] rx_tid       = '0;
    logic        rx_proto_err = 1'b0;
    logic [15:0] rx_len_field = '0;
    logic [7:0]  rx_unit_cap  = '0;
    logic [7:0]  rx_fcode_cap = '0;

    // results still owed by the block, oldest first
    framer_result_t pending_results[$];
    framer_result_t head_result;
    // bytes of the frame under construction
    logic [7:0] frame_q[$];

    int idle_pct    = 0;
    int stall_pct   = 0;
    int failures    = 0;
    int items_sent  = 0;
    int frames_sent = 0;
    int results_seen = 0;
    int quiet_cycles = 0;

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void add_pending(input logic [1:0] kind, input logic [7:0] out_byte,
                                        input logic last, input logic [7:0] unit,
                                        input logic [7:0] fcode, input logic [7:0] count,
                                        input logic [2:0] status);
        framer_result_t r;
        r.kind     = kind;
        r.out_byte = out_byte;
        r.last     = last;
        r.unit     = unit;
        r.fcode    = fcode;
        r.count    = count;
        r.status   = status;
        pending_results.push_back(r);
    endfunction

    // works out the results of one accepted transaction and advances the state
    function automatic void frame_predict(input framer_item_t it);
        int          limit;
        int          sz;
        int          cnt;
        logic [15:0] len;
        logic [2:0]  st;
        limit = (cfg_max_read > FRAME_BYTES - HDR_BYTES) ? FRAME_BYTES - HDR_BYTES
                                                         : int'(cfg_max_read);
        case (it.func)
            FUNC_TX_HDR: begin
                // a client bumps its id on every request but the first
                if (!cfg_server_mode) begin
                    hdr_tid  = hdr_tid + hdr_bump;
                    hdr_bump = 1'b1;
                end
                if (it.payload_length > FRAME_BYTES - HDR_BYTES) begin
                    add_pending(KIND_STATUS, 8'd0, 1'b1, 8'd0, 8'd0, 8'd0, ST_OVERFLOW);
                end else begin
                    len = 16'(it.payload_length + UNIT_FUNC_BYTES);
                    add_pending(KIND_TX, hdr_tid[15:8], 1'b0, 8'd0, 8'd0, 8'd0, ST_GOOD);
                    add_pending(KIND_TX, hdr_tid[7:0], 1'b0, 8'd0, 8'd0, 8'd0, ST_GOOD);
                    add_pending(KIND_TX, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0, ST_GOOD);
                    add_pending(KIND_TX, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0, ST_GOOD);
                    add_pending(KIND_TX, len[15:8], 1'b0, 8'd0, 8'd0, 8'd0, ST_GOOD);
                    add_pending(KIND_TX, len[7:0], 1'b0, 8'd0, 8'd0, 8'd0, ST_GOOD);
                    add_pending(KIND_TX, it.unit_id, 1'b0, 8'd0, 8'd0, 8'd0, ST_GOOD);
                    add_pending(KIND_TX, it.function_code, 1'b1, 8'd0, 8'd0, 8'd0, ST_GOOD);
                end
            end
            FUNC_TX_BYTE: begin
                add_pending(KIND_TX, it.data_byte, 1'b1, 8'd0, 8'd0, 8'd0, ST_GOOD);
            end
            FUNC_RX_BYTE: begin
                // header capture by byte position, payload after it
                case (rx_seen)
                    11'd0: rx_tid[15:8] = it.data_byte;
                    11'd1: rx_tid[7:0]  = it.data_byte;
                    11'd2, 11'd3: begin
                        if (it.data_byte != 8'd0) rx_proto_err = 1'b1;
                    end
                    11'd4: rx_len_field[15:8] = it.data_byte;
                    11'd5: rx_len_field[7:0]  = it.data_byte;
                    11'd6: rx_unit_cap  = it.data_byte;
                    11'd7: rx_fcode_cap = it.data_byte;
                    default: begin
                        if (int'(rx_seen) - HDR_BYTES < limit)
                            add_pending(KIND_RX_PAY, it.data_byte, !it.frame_end,
                                        8'd0, 8'd0, 8'd0, ST_GOOD);
                    end
                endcase
                if (rx_seen != RX_SEEN_MAX) rx_seen = rx_seen + 1'b1;
                if (it.frame_end) begin
                    sz  = rx_seen;
                    st  = ST_GOOD;
                    cnt = 0;
                    if (sz < HDR_BYTES)
                        st = ST_SHORT;
                    else if (rx_proto_err)
                        st = ST_PROTOCOL;
                    else if (sz > FRAME_BYTES || int'(rx_len_field) != sz - PREFIX_BYTES)
                        st = ST_LENGTH;
                    else if (cfg_server_mode)
                        hdr_tid = rx_tid;
                    else if (hdr_tid != rx_tid)
                        st = ST_TRANSACT;
                    if (st == ST_GOOD)
                        cnt = (sz - HDR_BYTES > limit) ? limit : sz - HDR_BYTES;
                    add_pending(KIND_STATUS, 8'd0, 1'b1, rx_unit_cap, rx_fcode_cap,
                                cnt[7:0], st);
                    rx_seen      = '0;
                    rx_tid       = '0;
                    rx_proto_err = 1'b0;
                    rx_len_field = '0;
                    rx_unit_cap  = '0;
                    rx_fcode_cap = '0;
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result side: random back pressure and checking
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s expected %0d got %0d", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: kind %0d byte %0d status %0d",
                       m_tuser, m_tdata[7:0], m_tdata[34:32]);
                failures++;
            end else begin
                head_result = pending_results.pop_front();
                check_field("out_kind", head_result.kind, m_tuser);
                check_field("out_byte", head_result.out_byte, m_tdata[7:0]);
                check_field("last", head_result.last, m_tlast);
                check_field("rx_unit_id", head_result.unit, m_tdata[15:8]);
                check_field("rx_function_code", head_result.fcode, m_tdata[23:16]);
                check_field("payload_count", head_result.count, m_tdata[31:24]);
                check_field("status", head_result.status, m_tdata[34:32]);
                results_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: any transaction on either stream resets the count
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // every field random, so fields the selector ignores still toggle
    function automatic framer_item_t rand_item();
        framer_item_t it;
        it.func           = 2'($urandom_range(0, 3));
        it.data_byte      = 8'($urandom);
        it.unit_id        = 8'($urandom);
        it.function_code  = 8'($urandom);
        it.payload_length = 16'($urandom);
        it.frame_end      = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // one input transaction, with random idle cycles ahead of it
    task automatic send_item(input framer_item_t it);
        @(negedge aclk);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = {it.payload_length, it.function_code, it.unit_id, it.data_byte};
        s_tuser  = it.func;
        s_tlast  = it.frame_end;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        frame_predict(it);
        if (it.func != FUNC_UNUSED) items_sent++;
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // block is idle once nothing is owed and the back end had time to finish
    task automatic config_idle();
        drop_valid();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (addr)
            REG_SERVER_MODE: cfg_server_mode = value[0];
            REG_MAX_READ:    cfg_max_read    = value[7:0];
            default: ;
        endcase
    endtask

    task automatic send_header(input logic [15:0] plen, input logic [7:0] unit,
                               input logic [7:0] fcode);
        framer_item_t it;
        it = rand_item();
        it.func           = FUNC_TX_HDR;
        it.payload_length = plen;
        it.unit_id        = unit;
        it.function_code  = fcode;
        send_item(it);
    endtask

    task automatic build_frame(input logic [15:0] tid, input logic [15:0] proto,
                               input logic [15:0] len_field, input logic [7:0] unit,
                               input logic [7:0] fcode, input int npay);
        frame_q.delete();
        frame_q.push_back(tid[15:8]);
        frame_q.push_back(tid[7:0]);
        frame_q.push_back(proto[15:8]);
        frame_q.push_back(proto[7:0]);
        frame_q.push_back(len_field[15:8]);
        frame_q.push_back(len_field[7:0]);
        frame_q.push_back(unit);
        frame_q.push_back(fcode);
        for (int i = 0; i < npay; i++) frame_q.push_back(8'($urandom));
    endtask

    task automatic shorten_frame(input int keep);
        while (frame_q.size() > keep) void'(frame_q.pop_back());
    endtask

    // sends the built frame, frame_end on its last byte; transmit payload
    // bytes may slip in between receive bytes
    task automatic send_frame(input int mix_pct);
        framer_item_t it;
        for (int i = 0; i < frame_q.size(); i++) begin
            if ($urandom_range(0, 99) < mix_pct) begin
                it = rand_item();
                it.func = FUNC_TX_BYTE;
                send_item(it);
            end
            it = rand_item();
            it.func      = FUNC_RX_BYTE;
            it.data_byte = frame_q[i];
            it.frame_end = (i == frame_q.size() - 1);
            send_item(it);
        end
        frames_sent++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // header requests at the size extremes, overflow, payload pass-through
    task automatic test_tx_header();
        framer_item_t it;
        send_header(16'd0, 8'h00, 8'h00);
        send_header(16'(FRAME_BYTES - HDR_BYTES), 8'hFF, 8'hFF);
        // one over capacity, then the largest length
        send_header(16'(FRAME_BYTES - HDR_BYTES + 1), 8'h5A, 8'hA5);
        send_header(16'hFFFF, 8'hFF, 8'hFF);
        // frame_end on a transmit byte is ignored
        it = rand_item();
        it.func = FUNC_TX_BYTE;
        it.data_byte = 8'h00;
        it.frame_end = 1'b1;
        send_item(it);
        it.data_byte = 8'hFF;
        it.frame_end = 1'b0;
        send_item(it);
        // unused selector gives nothing
        it.func = FUNC_UNUSED;
        it.data_byte = 8'hFF;
        it.unit_id = 8'hFF;
        it.function_code = 8'hFF;
        it.payload_length = 16'hFFFF;
        it.frame_end = 1'b1;
        send_item(it);
    endtask

    // each frame end check in turn
    task automatic test_rx_checks();
        build_frame(hdr_tid, 16'd0, 16'd3, 8'hFF, 8'hFF, 1);
        send_frame(0);
        // too short, frame ending inside the header
        build_frame(hdr_tid, 16'd0, 16'd2, 8'h11, 8'h22, 0);
        shorten_frame(2);
        send_frame(0);
        build_frame(hdr_tid, 16'h0001, 16'd2, 8'h33, 8'h44, 0);
        send_frame(0);
        build_frame(hdr_tid, 16'd0, 16'd3, 8'h55, 8'h66, 0);
        send_frame(0);
        // client id mismatch
        build_frame(hdr_tid ^ 16'h8000, 16'd0, 16'd2, 8'h00, 8'h00, 0);
        send_frame(0);
    endtask

    // frame size boundaries and the payload limit
    task automatic test_frame_limits();
        build_frame(hdr_tid, 16'd0, 16'(FRAME_BYTES - PREFIX_BYTES), 8'h01, 8'h03,
                    FRAME_BYTES - HDR_BYTES);
        send_frame(0);
        build_frame(hdr_tid, 16'd0, 16'(FRAME_BYTES + 1 - PREFIX_BYTES), 8'h01, 8'h03,
                    FRAME_BYTES + 1 - HDR_BYTES);
        send_frame(0);
        // limit zero passes no payload at all
        config_idle();
        apb_write(REG_MAX_READ, 32'd0);
        build_frame(hdr_tid, 16'd0, 16'd6, 8'h10, 8'h04, 4);
        send_frame(0);
        config_idle();
        apb_write(REG_MAX_READ, 32'd5);
        build_frame(hdr_tid, 16'd0, 16'd11, 8'h10, 8'h04, 9);
        send_frame(0);
        config_idle();
        apb_write(REG_MAX_READ, 32'(FRAME_BYTES - HDR_BYTES));
    endtask

    // id adoption in server mode and the return to client mode
    task automatic test_server_mode();
        config_idle();
        apb_write(REG_SERVER_MODE, 32'd1);
        send_header(16'd10, 8'h01, 8'h10);
        build_frame(16'hBEEF, 16'd0, 16'd4, 8'h02, 8'h03, 2);
        send_frame(0);
        send_header(16'd0, 8'h02, 8'h03);
        // failed frames leave the id alone
        build_frame(16'h1234, 16'h0100, 16'd2, 8'h02, 8'h03, 0);
        send_frame(0);
        build_frame(16'h4321, 16'd0, 16'd9, 8'h02, 8'h03, 0);
        send_frame(0);
        send_header(16'd1, 8'h04, 8'h05);
        config_idle();
        apb_write(REG_SERVER_MODE, 32'd0);
        send_header(16'd2, 8'h06, 8'h07);
        build_frame(hdr_tid, 16'd0, 16'd3, 8'h06, 8'h07, 1);
        send_frame(0);
    endtask

    // one random piece of traffic: frames half the time, some flawed
    task automatic run_episode();
        framer_item_t it;
        int           pick;
        int           npay;
        int           flaw;
        int           ntx;
        logic [15:0]  tid;
        logic [15:0]  proto;
        logic [15:0]  len_field;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            npay = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 60)
                                                 : $urandom_range(0, 10);
            tid = cfg_server_mode ? 16'($urandom) : hdr_tid;
            proto = 16'd0;
            len_field = 16'(npay + UNIT_FUNC_BYTES);
            flaw = $urandom_range(0, 9);
            case (flaw)
                0: proto = 16'($urandom_range(1, 65535));
                1: len_field = 16'($urandom);
                2: tid = 16'($urandom);
                default: ;
            endcase
            build_frame(tid, proto, len_field, 8'($urandom), 8'($urandom), npay);
            if (flaw == 3) shorten_frame($urandom_range(1, HDR_BYTES - 1));
            send_frame(10);
        end else if (pick < 85) begin
            send_header(($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 252)),
                        8'($urandom), 8'($urandom));
            ntx = $urandom_range(0, 4);
            for (int i = 0; i < ntx; i++) begin
                it = rand_item();
                it.func = FUNC_TX_BYTE;
                send_item(it);
            end
        end else if (pick < 97) begin
            // noise; a stray receive byte also ends any open frame
            it = rand_item();
            if (it.func == FUNC_RX_BYTE) it.frame_end = 1'b1;
            send_item(it);
        end else begin
            // sender holds off until the block has caught up
            drop_valid();
            wait_drained();
        end
    endtask

    // random traffic under each idling mix and register setting
    task automatic test_random();
        int idle_tab[4];
        int stall_tab[4];
        int target;
        idle_tab  = '{0, 70, 0, 38};
        stall_tab = '{0, 0, 70, 38};
        for (int p = 0; p < 4; p++) begin
            config_idle();
            case (p)
                0: begin
                    apb_write(REG_SERVER_MODE, 32'd0);
                    apb_write(REG_MAX_READ, 32'd252);
                end
                1: begin
                    apb_write(REG_SERVER_MODE, 32'd1);
                    apb_write(REG_MAX_READ, $urandom_range(0, 252));
                end
                2: begin
                    apb_write(REG_SERVER_MODE, 32'd0);
                    apb_write(REG_MAX_READ, $urandom_range(1, 16));
                end
                default: begin
                    apb_write(REG_SERVER_MODE, 32'd1);
                    apb_write(REG_MAX_READ, 32'd252);
                end
            endcase
            idle_pct  = idle_tab[p];
            stall_pct = stall_tab[p];
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) run_episode();
        end
        config_idle();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = FUNC_TX_HDR;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = REG_SERVER_MODE;
        pwdata   = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_tx_header();
        test_rx_checks();
        test_frame_limits();
        test_server_mode();
        test_random();

        // final drain, then anything still owed is a failure
        drop_valid();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            failures++;
        end

        $display("tb: %0d input transactions, %0d frames, %0d results checked",
                 items_sent, frames_sent, results_seen);
        $display("tb: client and server modes, payload limits 0 to 252, four idle mixes");
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
